// ----- rtl/sphfr_pkg.sv -----
`default_nettype none
package sphfr_pkg;

  // Item and frame sizes
  localparam int unsigned PORT_W      = 8;
  localparam int unsigned NUM_PORTS   = 7;
  localparam int unsigned IN_W        = PORT_W * NUM_PORTS;
  localparam int unsigned FRAME_BYTES = 23;
  localparam int unsigned FRAME_W     = FRAME_BYTES * 8;
  localparam int unsigned XOR_BYTES   = 19;

  // Item kinds carried on tuser
  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_TICK   = 1'b1;

  // Fixed frame characters
  localparam logic [7:0] CH_AT   = 8'h40;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_A    = 8'h41;

  localparam logic [3:0] ID_RADIX = 4'd10;

  // Upper-case ASCII hex digit of one nibble
  function automatic logic [7:0] to_hex_ascii(input logic [3:0] nib);
    logic [7:0] c;
    if (nib < 4'd10) begin
      c = CH_ZERO + {4'b0000, nib};
    end else begin
      c = CH_A + {4'b0000, nib - 4'd10};
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/sticky_pin_hex_frame_reporter.sv -----
// Sticky pin activity reporter.
// Input channel (in_*): one item per handshake. in_tuser selects the kind:
// a sample item ORs ports A, C, L, B, F, K and the low nibble of D into
// sticky accumulators; a tick item advances the 16-bit tick count and, if
// any accumulator is set, emits a 23-byte ASCII frame and clears them.
// Output channel (out_*): each frame goes out as COPIES identical items,
// 184 bits of tdata with byte 0 lowest; tlast marks the final copy.
// cfg_wr_en / cfg_wr_data load the machine id digit; the user must write it only
// while the block idles, as the block itself does not enforce this. Accepted items
// wait in the input register; a reporting tick loads its frame when it advances.
// Throughput: one item per cycle for samples and ticks with nothing to
// report. A reporting tick occupies the output register until its last
// copy is taken, so the input stalls when a second report would overwrite it.
// When the receiver holds out_tready low the output register holds its
// item; samples keep flowing until a reporting tick reaches the input
// register, then in_tready drops. Synchronous reset (rst_n low) clears
// the accumulators, tick count, machine id and both valid flags.
`default_nettype none
module sticky_pin_hex_frame_reporter #(
  parameter int unsigned COPIES = 3
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // tdata: port_a[7:0], port_c[15:8], port_l[23:16], port_b[31:24],
  //        port_f[39:32], port_k[47:40], port_d[55:48]
  input  wire logic [sphfr_pkg::IN_W-1:0]    in_tdata,
  // tuser: mode[0]
  input  wire logic                          in_tuser,
  input  wire logic                          in_tvalid,
  output      logic                          in_tready,
  // tdata: frame_low[63:0], frame_mid[127:64], frame_high[183:128]
  output      logic [sphfr_pkg::FRAME_W-1:0] out_tdata,
  output      logic                          out_tlast,
  output      logic                          out_tvalid,
  input  wire logic                          out_tready,
  input  wire logic                          cfg_wr_en,
  input  wire logic [3:0]                    cfg_wr_data
);
  import sphfr_pkg::*;

  localparam int unsigned CNT_W = (COPIES > 1) ? $clog2(COPIES) : 1;
  localparam logic [CNT_W-1:0] LAST_COPY = CNT_W'(COPIES - 1);

  // Input register
  logic              s1_valid_r;
  logic              s1_mode_r;
  logic [IN_W-1:0]   s1_data_r;

  // State
  logic [3:0]        machine_id_r;
  logic [7:0]        acc_a_r, acc_c_r, acc_l_r, acc_b_r, acc_f_r, acc_k_r;
  logic [3:0]        acc_d_r;
  logic [15:0]       tick_r;

  // Output register
  logic              out_valid_r;
  logic [CNT_W-1:0]  copy_r;
  logic [FRAME_W-1:0] frame_r;

  logic              any_set;
  logic              report;
  logic              is_last;
  logic              out_take;
  logic              out_free;
  logic              s1_adv;
  logic [15:0]       tick_inc;
  logic [3:0]        id_digit;
  logic [7:0]        fb [FRAME_BYTES];
  logic [7:0]        xsum;
  logic [FRAME_W-1:0] frame_nxt;

  // Handshake and advance control
  assign any_set  = |{acc_a_r, acc_c_r, acc_l_r, acc_b_r, acc_f_r, acc_k_r, acc_d_r};
  assign report   = (s1_mode_r == MODE_TICK) && any_set;
  assign is_last  = (copy_r == LAST_COPY);
  assign out_take = out_valid_r && out_tready;
  assign out_free = !out_valid_r || (out_take && is_last);
  assign s1_adv   = s1_valid_r && (!report || out_free);
  assign in_tready = !s1_valid_r || s1_adv;

  assign tick_inc = tick_r + 16'd1;
  assign id_digit = (machine_id_r >= ID_RADIX) ? (machine_id_r - ID_RADIX) : machine_id_r;

  // Build the frame from accumulators and the advanced count
  always_comb begin
    fb[0]  = CH_AT;
    fb[1]  = CH_ZERO + {4'b0000, id_digit};
    fb[2]  = to_hex_ascii(acc_a_r[7:4]);
    fb[3]  = to_hex_ascii(acc_a_r[3:0]);
    fb[4]  = to_hex_ascii(acc_c_r[7:4]);
    fb[5]  = to_hex_ascii(acc_c_r[3:0]);
    fb[6]  = to_hex_ascii(acc_l_r[7:4]);
    fb[7]  = to_hex_ascii(acc_l_r[3:0]);
    fb[8]  = to_hex_ascii(acc_b_r[7:4]);
    fb[9]  = to_hex_ascii(acc_b_r[3:0]);
    fb[10] = to_hex_ascii(acc_f_r[7:4]);
    fb[11] = to_hex_ascii(acc_f_r[3:0]);
    fb[12] = to_hex_ascii(acc_k_r[7:4]);
    fb[13] = to_hex_ascii(acc_k_r[3:0]);
    fb[14] = to_hex_ascii(acc_d_r);
    fb[15] = to_hex_ascii(tick_inc[15:12]);
    fb[16] = to_hex_ascii(tick_inc[11:8]);
    fb[17] = to_hex_ascii(tick_inc[7:4]);
    fb[18] = to_hex_ascii(tick_inc[3:0]);
    xsum = 8'h00;
    for (int i = 0; i < XOR_BYTES; i++) begin
      xsum = xsum ^ fb[i];
    end
    fb[19] = to_hex_ascii(xsum[7:4]);
    fb[20] = to_hex_ascii(xsum[3:0]);
    fb[21] = CH_HASH;
    fb[22] = CH_LF;
    for (int i = 0; i < FRAME_BYTES; i++) begin
      frame_nxt[8*i +: 8] = fb[i];
    end
  end

  // Capture accepted items
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
    if (in_tready && in_tvalid) begin
      s1_mode_r <= in_tuser;
      s1_data_r <= in_tdata;
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      machine_id_r <= 4'd0;
    end else if (cfg_wr_en) begin
      machine_id_r <= cfg_wr_data;
    end
  end

  // Accumulate samples, count ticks, clear after a report
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_a_r <= '0;
      acc_c_r <= '0;
      acc_l_r <= '0;
      acc_b_r <= '0;
      acc_f_r <= '0;
      acc_k_r <= '0;
      acc_d_r <= '0;
      tick_r  <= '0;
    end else if (s1_adv) begin
      if (s1_mode_r == MODE_SAMPLE) begin
        acc_a_r <= acc_a_r | s1_data_r[7:0];
        acc_c_r <= acc_c_r | s1_data_r[15:8];
        acc_l_r <= acc_l_r | s1_data_r[23:16];
        acc_b_r <= acc_b_r | s1_data_r[31:24];
        acc_f_r <= acc_f_r | s1_data_r[39:32];
        acc_k_r <= acc_k_r | s1_data_r[47:40];
        acc_d_r <= acc_d_r | s1_data_r[51:48];
      end else begin
        tick_r <= tick_inc;
        if (any_set) begin
          acc_a_r <= '0;
          acc_c_r <= '0;
          acc_l_r <= '0;
          acc_b_r <= '0;
          acc_f_r <= '0;
          acc_k_r <= '0;
          acc_d_r <= '0;
        end
      end
    end
  end

  // Output register: hold the frame and step through its copies
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      copy_r      <= '0;
    end else if (s1_adv && report) begin
      out_valid_r <= 1'b1;
      copy_r      <= '0;
    end else if (out_take) begin
      if (is_last) begin
        out_valid_r <= 1'b0;
      end else begin
        copy_r <= copy_r + CNT_W'(1);
      end
    end
    if (s1_adv && report) begin
      frame_r <= frame_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = frame_r;
  assign out_tlast  = is_last;

endmodule
`default_nettype wire

// ----- rtl/sphfr_checker.sv -----
`default_nettype none
module sphfr_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic [sphfr_pkg::IN_W-1:0]    in_tdata,
  input wire logic                          in_tuser,
  input wire logic                          in_tvalid,
  input wire logic                          in_tready,
  input wire logic [sphfr_pkg::FRAME_W-1:0] out_tdata,
  input wire logic                          out_tlast,
  input wire logic                          out_tvalid,
  input wire logic                          out_tready,
  input wire logic                          cfg_wr_en,
  input wire logic [3:0]                    cfg_wr_data
);
  import sphfr_pkg::*;

  logic unused_ok;
  assign unused_ok = ^{in_tdata, in_tuser, in_tvalid, in_tready, cfg_wr_en, cfg_wr_data};

  // Stalled output item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output item changed while stalled");

  // A copy that is not the last is followed at once by an identical copy
  a_copy_repeat: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tvalid && out_tdata == $past(out_tdata))
    else $error("frame copies differ or are broken up");

  // Every frame carries its fixed start and end characters
  a_frame_marks: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[7:0] == CH_AT && out_tdata[175:168] == CH_HASH
                   && out_tdata[183:176] == CH_LF)
    else $error("frame markers wrong");

  // Reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind sticky_pin_hex_frame_reporter sphfr_checker u_sphfr_checker (.*);
`default_nettype wire
